### hdl/dnbs_pkg.sv
// shared constants and codes for the directional nearest box selector
package dnbs_pkg;

  localparam int MAX_CANDIDATES_DEF = 256;

  localparam int COORD_BITS = 16;
  localparam int EXT_BITS   = COORD_BITS - 1;
  localparam int GAP_BITS   = COORD_BITS + 2;
  localparam int CROSS_BITS = COORD_BITS + 2;
  localparam int INDEX_BITS = 8;

  localparam int IN_DATA_BITS  = 72;
  localparam int IN_USER_BITS  = 2;
  localparam int OUT_DATA_BITS = 16;

  typedef enum logic [1:0] {
    CMD_BEGIN = 2'd0,
    CMD_CAND  = 2'd1,
    CMD_END   = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  localparam logic [2:0] DIR_NONE  = 3'd0;
  localparam logic [2:0] DIR_UP    = 3'd1;
  localparam logic [2:0] DIR_DOWN  = 3'd2;
  localparam logic [2:0] DIR_LEFT  = 3'd3;
  localparam logic [2:0] DIR_RIGHT = 3'd4;

endpackage

### hdl/directional_nearest_box_select_core.sv
// directional nearest box selector: origin load, candidate scan, report on end
// result path: an end transaction passes the input register, then the output
//   register, and waits in the input register while an unaccepted result is held
// throughput: one transaction per cycle except while an end waits for the output;
//   each candidate is compared combinationally against best-ahead and best-behind
// reset: synchronous rst clears the query, the search and both valid flags;
//   direction reads as none until the first begin transaction
module directional_nearest_box_select_core #(
  parameter int MAX_CANDIDATES = dnbs_pkg::MAX_CANDIDATES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // rect_x[15:0] rect_y[31:16] rect_w[46:32] rect_h[61:47] move_dir[64:62]
  // wrap_enable[65], zero above
  input  logic [dnbs_pkg::IN_DATA_BITS-1:0]  s_axis_tdata,
  // command[1:0]
  input  logic [dnbs_pkg::IN_USER_BITS-1:0]  s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // found[0] chosen_index[8:1], zero above
  output logic [dnbs_pkg::OUT_DATA_BITS-1:0] m_axis_tdata
);
  import dnbs_pkg::*;

  localparam int CNT_W = $clog2(MAX_CANDIDATES + 1);

  // input register
  logic                    in_valid;
  logic [IN_DATA_BITS-1:0] in_data;
  cmd_t                    in_cmd;

  // query and search state
  logic signed [COORD_BITS-1:0] org_x, org_y;
  logic        [EXT_BITS-1:0]   org_w, org_h;
  logic [2:0]                   query_dir;
  logic                         query_wrap;
  logic [CNT_W-1:0]             cand_cnt;

  logic                         ahead_valid, behind_valid;
  logic [INDEX_BITS-1:0]        ahead_index, behind_index;
  logic signed [GAP_BITS-1:0]   ahead_gap, behind_gap;
  logic [CROSS_BITS-1:0]        ahead_cross, behind_cross;

  logic                         out_found;
  logic [INDEX_BITS-1:0]        out_index;

  // candidate fields
  logic signed [COORD_BITS-1:0] c_x, c_y;
  logic        [EXT_BITS-1:0]   c_w, c_h;
  logic [2:0]                   c_dir;
  logic                         c_wrap;

  logic signed [GAP_BITS-1:0]   gap_up, gap_down, gap_left, gap_right;
  logic signed [GAP_BITS-1:0]   gap_fwd, gap_rev;
  logic signed [GAP_BITS:0]     cen_c, cen_o, cross_diff;
  logic [CROSS_BITS-1:0]        cross_abs;
  logic [EXT_BITS-1:0]          ext_min;
  logic signed [GAP_BITS+1:0]   tol_fwd, tol_rev;
  logic                         dir_ok, vertical, skip, room;
  logic                         is_ahead, is_behind, better_ahead, better_behind;
  logic                         advance, out_free, found_next;

  assign c_x    = in_data[15:0];
  assign c_y    = in_data[31:16];
  assign c_w    = in_data[46:32];
  assign c_h    = in_data[61:47];
  assign c_dir  = in_data[64:62];
  assign c_wrap = in_data[65];

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign advance       = in_valid && ((in_cmd != CMD_END) || out_free);
  assign s_axis_tready = !in_valid || advance;

  assign dir_ok   = (query_dir == DIR_UP) || (query_dir == DIR_DOWN) ||
                    (query_dir == DIR_LEFT) || (query_dir == DIR_RIGHT);
  assign vertical = (query_dir == DIR_UP) || (query_dir == DIR_DOWN);
  assign room     = cand_cnt < CNT_W'(MAX_CANDIDATES);

  always_comb begin
    gap_up    = GAP_BITS'(org_y) - (GAP_BITS'(c_y) + GAP_BITS'(c_h));
    gap_down  = GAP_BITS'(c_y) - (GAP_BITS'(org_y) + GAP_BITS'(org_h));
    gap_left  = GAP_BITS'(org_x) - (GAP_BITS'(c_x) + GAP_BITS'(c_w));
    gap_right = GAP_BITS'(c_x) - (GAP_BITS'(org_x) + GAP_BITS'(org_w));

    unique case (query_dir)
      DIR_UP: begin
        gap_fwd = gap_up;
        gap_rev = gap_down;
      end
      DIR_DOWN: begin
        gap_fwd = gap_down;
        gap_rev = gap_up;
      end
      DIR_LEFT: begin
        gap_fwd = gap_left;
        gap_rev = gap_right;
      end
      default: begin
        gap_fwd = gap_right;
        gap_rev = gap_left;
      end
    endcase

    // doubled centres so the offset stays exact
    if (vertical) begin
      cen_c   = ((GAP_BITS+1)'(c_x) <<< 1) + (GAP_BITS+1)'(c_w);
      cen_o   = ((GAP_BITS+1)'(org_x) <<< 1) + (GAP_BITS+1)'(org_w);
      ext_min = (org_h < c_h) ? org_h : c_h;
    end else begin
      cen_c   = ((GAP_BITS+1)'(c_y) <<< 1) + (GAP_BITS+1)'(c_h);
      cen_o   = ((GAP_BITS+1)'(org_y) <<< 1) + (GAP_BITS+1)'(org_h);
      ext_min = (org_w < c_w) ? org_w : c_w;
    end
    cross_diff = cen_c - cen_o;
    cross_abs  = cross_diff[GAP_BITS] ? CROSS_BITS'(-cross_diff) : CROSS_BITS'(cross_diff);

    // overlap tolerance of half the smaller extent, tested doubled
    tol_fwd = ((GAP_BITS+2)'(gap_fwd) <<< 1) + (GAP_BITS+2)'(ext_min);
    tol_rev = ((GAP_BITS+2)'(gap_rev) <<< 1) + (GAP_BITS+2)'(ext_min);

    skip = !dir_ok || (c_w == '0) || (c_h == '0) ||
           ((c_x == org_x) && (c_y == org_y) && (c_w == org_w) && (c_h == org_h));

    is_ahead  = !skip && !tol_fwd[GAP_BITS+1];
    is_behind = !skip && tol_fwd[GAP_BITS+1] && query_wrap && !tol_rev[GAP_BITS+1];

    better_ahead  = !ahead_valid || (gap_fwd < ahead_gap) ||
                    ((gap_fwd == ahead_gap) && (cross_abs < ahead_cross));
    better_behind = !behind_valid || (gap_rev > behind_gap) ||
                    ((gap_rev == behind_gap) && (cross_abs < behind_cross));

    found_next = dir_ok && (ahead_valid || (query_wrap && behind_valid));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid      <= 1'b0;
      in_cmd        <= CMD_NOP;
      query_dir     <= DIR_NONE;
      query_wrap    <= 1'b0;
      cand_cnt      <= '0;
      ahead_valid   <= 1'b0;
      behind_valid  <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid <= s_axis_tvalid;
        in_cmd   <= cmd_t'(s_axis_tuser);
      end

      if (advance && (in_cmd == CMD_END)) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end

      if (advance) begin
        unique case (in_cmd)
          CMD_BEGIN: begin
            query_dir    <= c_dir;
            query_wrap   <= c_wrap;
            cand_cnt     <= '0;
            ahead_valid  <= 1'b0;
            behind_valid <= 1'b0;
          end
          CMD_CAND: begin
            if (room) begin
              cand_cnt <= cand_cnt + 1'b1;
              if (is_ahead && better_ahead) begin
                ahead_valid <= 1'b1;
              end
              if (is_behind && better_behind) begin
                behind_valid <= 1'b1;
              end
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s_axis_tready) begin
      in_data <= s_axis_tdata;
    end
    if (advance && (in_cmd == CMD_BEGIN)) begin
      org_x <= c_x;
      org_y <= c_y;
      org_w <= c_w;
      org_h <= c_h;
    end
    if (advance && (in_cmd == CMD_CAND) && room) begin
      if (is_ahead && better_ahead) begin
        ahead_index <= INDEX_BITS'(cand_cnt);
        ahead_gap   <= gap_fwd;
        ahead_cross <= cross_abs;
      end
      if (is_behind && better_behind) begin
        behind_index <= INDEX_BITS'(cand_cnt);
        behind_gap   <= gap_rev;
        behind_cross <= cross_abs;
      end
    end
    if (advance && (in_cmd == CMD_END)) begin
      out_found <= found_next;
      if (!found_next) begin
        out_index <= '0;
      end else if (ahead_valid) begin
        out_index <= ahead_index;
      end else begin
        out_index <= behind_index;
      end
    end
  end

  assign m_axis_tdata = {{(OUT_DATA_BITS-INDEX_BITS-1){1'b0}}, out_index, out_found};

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cand_cnt <= CNT_W'(MAX_CANDIDATES))
    else $error("candidate count past capacity");

  a_ahead_dir: assert property (@(posedge clk) disable iff (rst)
    ahead_valid || behind_valid |-> dir_ok)
    else $error("best box held without a valid direction");

  a_begin_clears: assert property (@(posedge clk) disable iff (rst)
    advance && (in_cmd == CMD_BEGIN) |=> !ahead_valid && !behind_valid && (cand_cnt == '0))
    else $error("begin did not clear the search");

  a_not_found_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[0] |-> (m_axis_tdata[INDEX_BITS:1] == '0))
    else $error("not-found result carries an index");

  a_stall_only_busy: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> in_valid && (in_cmd == CMD_END) && m_axis_tvalid)
    else $error("input stalled with no end transaction waiting");

endmodule
